// File: hdl/gld_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and code-table helpers for the GIF LZW pixel decoder.
package gld_pkg;

    localparam int MAX_CODE_BITS = 12;
    localparam int PENDING_DEPTH = 4;
    localparam int TBL_SIZE      = 1 << MAX_CODE_BITS;
    localparam int NF_W          = MAX_CODE_BITS + 1;
    localparam int PEND_CW       = $clog2(PENDING_DEPTH + 1);
    localparam int PEND_IW       = $clog2(PENDING_DEPTH);
    localparam int CFG_AW        = 4;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_END  = 2'd1,
        ST_TERM = 2'd2,
        ST_BAD  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_MCS    = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2,
        CFG_INTL   = 2'd3
    } t_cfg_idx;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_PULL = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic        byte_taken;
        logic        pixel_valid;
        logic [7:0]  pixel_index;
        logic [15:0] pixel_col;
        logic [15:0] pixel_row;
        logic        row_end;
        logic [1:0]  status;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UNPACK,
        S_RUN,
        S_RWAIT,
        S_POP,
        S_POPW,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        E_IDLE,
        E_WALK,
        E_FIRST,
        E_FIX
    } t_exp_state;

    typedef struct packed {
        logic                     run;
        logic                     pop;
        logic [MAX_CODE_BITS-1:0] code;
        logic [NF_W-1:0]          last;
        logic [NF_W-1:0]          clear;
    } t_exp_cmd;

    typedef struct packed {
        logic       done;
        logic       empty;
        logic [7:0] pix;
    } t_exp_sts;

    typedef struct packed {
        logic [NF_W-1:0] nf;
        logic [3:0]      w;
        t_status         k;
    } t_adv;

    function automatic logic [3:0] sat_mcs(input logic [3:0] v);
        logic [3:0] r;
        r = v;
        if (v < 4'd2) r = 4'd2;
        else if (v > 4'd8) r = 4'd8;
        return r;
    endfunction

    function automatic logic [NF_W-1:0] width_mask(input logic [3:0] w);
        logic [NF_W:0] t;
        t = (NF_W + 1)'(1) << w;
        return NF_W'(t - (NF_W + 1)'(1));
    endfunction

    // One code applied to the (next free, width) pair.
    function automatic t_adv adv_code(input logic [MAX_CODE_BITS-1:0] code,
                                      input logic [NF_W-1:0] nf,
                                      input logic [3:0] w,
                                      input logic [3:0] m);
        logic [NF_W-1:0] clr;
        logic [NF_W-1:0] c;
        logic [NF_W-1:0] nn;
        t_adv r;
        clr  = NF_W'(1) << m;
        c    = NF_W'(code);
        nn   = nf + NF_W'(1);
        r.nf = nf;
        r.w  = w;
        r.k  = ST_RUN;
        if (c == clr) begin
            r.nf = clr + NF_W'(1);
            r.w  = m + 4'd1;
        end else if (c == clr + NF_W'(1)) begin
            r.k = ST_END;
        end else if (c > clr + NF_W'(1) && c > nf) begin
            r.k = ST_BAD;
        end else if (nf < NF_W'(TBL_SIZE)) begin
            r.nf = nn;
            if ((nn & width_mask(w)) == '0 && nn < NF_W'(TBL_SIZE)
                && w < 4'(MAX_CODE_BITS)) begin
                r.w = w + 4'd1;
            end
        end
        return r;
    endfunction

endpackage

// File: hdl/gif_lzw_pixel_decoder_core.sv
`timescale 1ns / 1ps
// GIF LZW decoder: takes image-data bytes (sub-block lengths included) and
// returns colour indices with their column and row. A push of a data byte
// unpacks the codes that it completes, one per cycle and at most four; a
// length byte or a refused push goes straight to the result. A pull whose
// pixel is already on the stack pops it. Otherwise each waiting code is first
// applied (all that a clear code needs) and expanded: the prefix chain is
// walked one table entry per cycle through the prefix/suffix memories, then the
// first byte is pushed (and also put at the stack bottom when the code names
// the entry being built). The stack is then checked before the pop. Results
// leave through a register; the input is stalled while an item is in work or
// a result cannot yet be handed off.
module gif_lzw_pixel_decoder_core
    import gld_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_state r_state, n_state;

    logic [3:0]  r_mcs;
    logic [15:0] r_width, r_height;
    logic        r_intl;

    logic [23:0]           r_window, n_window;
    logic [4:0]            r_bits, n_bits;
    logic [3:0]            r_w, n_w, r_uw, n_uw;
    logic [NF_W-1:0]       r_nf, n_nf, r_unf, n_unf;
    logic                  r_udone, n_udone;
    logic [MAX_CODE_BITS-1:0] r_pend [PENDING_DEPTH];
    logic [PEND_CW-1:0]    r_pend_n, n_pend_n, r_pend_rd, n_pend_rd;
    logic [7:0]            r_sub, n_sub;
    t_status               r_stop, n_stop;
    t_out_item             r_res, n_res, r_out, n_out;
    logic                  r_out_valid, n_out_valid;
    logic                  pend_we;

    logic                  in_acc, cfg_wr, out_free;
    logic                  push_ok, u_go, run_go;
    logic [3:0]            m_eff, m_new;
    logic [NF_W-1:0]       clear;
    logic [MAX_CODE_BITS-1:0] u_code, head_code;
    t_adv                  uadv, radv;
    t_exp_cmd              exp_cmd;
    t_exp_sts              exp_sts;
    logic                  rs_step;
    logic [15:0]           rs_col, rs_row;
    logic                  rs_row_end;

    gld_expand u_expand (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(exp_cmd), .o_sts(exp_sts)
    );

    gld_raster u_raster (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(rs_step),
        .i_width(r_width), .i_height(r_height), .i_interlaced(r_intl),
        .o_col(rs_col), .o_row(rs_row), .o_row_end(rs_row_end)
    );

    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign m_eff = sat_mcs(r_mcs);
    assign m_new = sat_mcs(pwdata[3:0]);
    assign clear = NF_W'(1) << m_eff;

    assign push_ok = r_stop == ST_RUN && exp_sts.empty && r_pend_n == '0
                     && r_bits <= 5'd16;
    assign u_code  = MAX_CODE_BITS'(NF_W'(r_window[NF_W-1:0]) & width_mask(r_uw));
    assign u_go    = !r_udone && r_bits >= 5'(r_uw)
                     && r_pend_n < PEND_CW'(PENDING_DEPTH);
    assign uadv    = adv_code(u_code, r_unf, r_uw, m_eff);
    assign head_code = r_pend[r_pend_rd[PEND_IW-1:0]];
    assign run_go  = r_pend_rd < r_pend_n && r_stop == ST_RUN && exp_sts.empty;
    assign radv    = adv_code(head_code, r_nf, r_w, m_eff);

    always_comb begin
        case (paddr[3:2])
            CFG_MCS:    prdata = {28'd0, r_mcs};
            CFG_WIDTH:  prdata = {16'd0, r_width};
            CFG_HEIGHT: prdata = {16'd0, r_height};
            CFG_INTL:   prdata = {31'd0, r_intl};
            default:    prdata = '0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.req_type == REQ_PULL) begin
                        n_state = exp_sts.empty ? S_RUN : S_POP;
                    end else if (push_ok && r_sub != '0) begin
                        n_state = S_UNPACK;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_UNPACK: if (!u_go) n_state = S_DONE;
            S_RUN: begin
                if (run_go) begin
                    if (radv.k == ST_RUN && NF_W'(head_code) != clear) n_state = S_RWAIT;
                end else begin
                    n_state = exp_sts.empty ? S_DONE : S_POP;
                end
            end
            S_RWAIT: if (exp_sts.done) n_state = S_RUN;
            S_POP:   n_state = S_POPW;
            S_POPW:  n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_window    = r_window;
        n_bits      = r_bits;
        n_w         = r_w;
        n_nf        = r_nf;
        n_uw        = r_uw;
        n_unf       = r_unf;
        n_udone     = r_udone;
        n_pend_n    = r_pend_n;
        n_pend_rd   = r_pend_rd;
        n_sub       = r_sub;
        n_stop      = r_stop;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        pend_we     = 1'b0;
        rs_step     = 1'b0;
        exp_cmd     = '0;
        exp_cmd.code  = head_code;
        exp_cmd.last  = r_nf;
        exp_cmd.clear = clear;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res = '0;
                    if (i_in_data.req_type == REQ_PUSH && push_ok) begin
                        n_res.byte_taken = 1'b1;
                        if (r_sub == '0) begin
                            if (i_in_data.data_byte == '0) n_stop = ST_TERM;
                            else n_sub = i_in_data.data_byte;
                        end else begin
                            n_sub     = r_sub - 8'd1;
                            n_window  = r_window | 24'({16'd0, i_in_data.data_byte} << r_bits);
                            n_bits    = r_bits + 5'd8;
                            n_pend_rd = '0;
                            n_unf     = r_nf;
                            n_uw      = r_w;
                            n_udone   = 1'b0;
                        end
                    end
                end
            end
            S_UNPACK: begin
                if (u_go) begin
                    pend_we  = 1'b1;
                    n_window = r_window >> r_uw;
                    n_bits   = r_bits - 5'(r_uw);
                    n_pend_n = r_pend_n + PEND_CW'(1);
                    n_unf    = uadv.nf;
                    n_uw     = uadv.w;
                    if (uadv.k != ST_RUN) n_udone = 1'b1;
                end
            end
            S_RUN: begin
                if (run_go) begin
                    n_pend_rd = r_pend_rd + PEND_CW'(1);
                    n_nf      = radv.nf;
                    n_w       = radv.w;
                    if (radv.k != ST_RUN) begin
                        n_stop = radv.k;
                    end else if (NF_W'(head_code) != clear) begin
                        exp_cmd.run = 1'b1;
                    end
                end else if (r_pend_rd >= r_pend_n || r_stop != ST_RUN) begin
                    n_pend_n  = '0;
                    n_pend_rd = '0;
                end
            end
            S_POP: exp_cmd.pop = 1'b1;
            S_POPW: begin
                rs_step           = 1'b1;
                n_res.pixel_valid = 1'b1;
                n_res.pixel_index = exp_sts.pix;
                n_res.pixel_col   = rs_col;
                n_res.pixel_row   = rs_row;
                n_res.row_end     = rs_row_end;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out        = r_res;
                    n_out.status = r_stop;
                    n_out_valid  = 1'b1;
                end
            end
            default: ;
        endcase
        if (cfg_wr && paddr[3:2] == CFG_MCS) begin
            n_w  = m_new + 4'd1;
            n_nf = (NF_W'(1) << m_new) + NF_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mcs       <= 4'd8;
            r_width     <= 16'd1;
            r_height    <= 16'd1;
            r_intl      <= 1'b0;
            r_window    <= '0;
            r_bits      <= '0;
            r_w         <= 4'd9;
            r_nf        <= NF_W'(257);
            r_udone     <= 1'b1;
            r_pend_n    <= '0;
            r_pend_rd   <= '0;
            r_sub       <= '0;
            r_stop      <= ST_RUN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_window    <= n_window;
            r_bits      <= n_bits;
            r_w         <= n_w;
            r_nf        <= n_nf;
            r_udone     <= n_udone;
            r_pend_n    <= n_pend_n;
            r_pend_rd   <= n_pend_rd;
            r_sub       <= n_sub;
            r_stop      <= n_stop;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                case (paddr[3:2])
                    CFG_MCS:    r_mcs    <= pwdata[3:0];
                    CFG_WIDTH:  r_width  <= pwdata[15:0];
                    CFG_HEIGHT: r_height <= pwdata[15:0];
                    CFG_INTL:   r_intl   <= pwdata[0];
                    default: ;
                endcase
            end
        end
        r_unf <= n_unf;
        r_uw  <= n_uw;
        r_res <= n_res;
        r_out <= n_out;
        if (pend_we) r_pend[r_pend_n[PEND_IW-1:0]] <= u_code;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_pend_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_rd <= r_pend_n)
        else $error("pending read index past fill count");
    a_window_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits <= 5'd24)
        else $error("bit window overfilled");
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.byte_taken && r_out.pixel_valid))
        else $error("result marks both a taken byte and a pixel");
    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_stop) != ST_RUN && $past(i_rst_n) |-> r_stop == $past(r_stop))
        else $error("stop status changed after stop");

endmodule

// File: hdl/gld_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module gld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/gld_expand.sv
`timescale 1ns / 1ps
// Code expander: prefix/suffix tables, prefix-chain walk and the pixel stack.
module gld_expand
    import gld_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_exp_cmd i_cmd,
    output t_exp_sts o_sts
);

    t_exp_state r_state, n_state;
    logic [NF_W-1:0]          r_count, n_count;
    logic [MAX_CODE_BITS-1:0] r_code, n_code;
    logic [NF_W-1:0]          r_last, n_last;
    logic [NF_W-1:0]          r_clear, n_clear;
    logic [7:0]               r_first, n_first;
    logic                     r_done, n_done;

    logic                     pf_we, sf_we, st_we;
    logic [MAX_CODE_BITS-1:0] pf_waddr, sf_waddr, st_waddr;
    logic [MAX_CODE_BITS-1:0] pf_wdata, pf_rdata, tb_raddr, st_raddr;
    logic [7:0]               sf_wdata, sf_rdata, st_wdata, st_rdata;
    logic                     walk_more;
    logic [NF_W:0]            cnt_next2;

    gld_ram #(.WIDTH(MAX_CODE_BITS), .DEPTH(TBL_SIZE)) u_prefix (
        .i_clk(i_clk), .i_we(pf_we), .i_waddr(pf_waddr), .i_wdata(pf_wdata),
        .i_raddr(tb_raddr), .o_rdata(pf_rdata)
    );

    gld_ram #(.WIDTH(8), .DEPTH(TBL_SIZE)) u_suffix (
        .i_clk(i_clk), .i_we(sf_we), .i_waddr(sf_waddr), .i_wdata(sf_wdata),
        .i_raddr(tb_raddr), .o_rdata(sf_rdata)
    );

    gld_ram #(.WIDTH(8), .DEPTH(TBL_SIZE)) u_stack (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wdata(st_wdata),
        .i_raddr(st_raddr), .o_rdata(st_rdata)
    );

    // the next chain address comes straight off the prefix read port
    assign tb_raddr  = (r_state == E_WALK) ? pf_rdata : i_cmd.code;
    assign st_raddr  = MAX_CODE_BITS'(r_count - NF_W'(1));
    assign cnt_next2 = {1'b0, r_count} + (NF_W + 1)'(2);
    assign walk_more = NF_W'(pf_rdata) >= r_clear && cnt_next2 < (NF_W + 1)'(TBL_SIZE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            E_IDLE: begin
                if (i_cmd.run) begin
                    n_state = (NF_W'(i_cmd.code) >= i_cmd.clear) ? E_WALK : E_FIRST;
                end
            end
            E_WALK: begin
                if (!walk_more) n_state = E_FIRST;
            end
            E_FIRST: begin
                n_state = (NF_W'(r_code) == r_last) ? E_FIX : E_IDLE;
            end
            E_FIX: n_state = E_IDLE;
            default: n_state = E_IDLE;
        endcase
    end

    always_comb begin
        n_count  = r_count;
        n_code   = r_code;
        n_last   = r_last;
        n_clear  = r_clear;
        n_first  = r_first;
        n_done   = 1'b0;
        pf_we    = 1'b0;
        pf_waddr = '0;
        pf_wdata = i_cmd.code;
        sf_we    = 1'b0;
        sf_waddr = r_last[MAX_CODE_BITS-1:0];
        sf_wdata = r_first;
        st_we    = 1'b0;
        st_waddr = r_count[MAX_CODE_BITS-1:0];
        st_wdata = r_first;
        case (r_state)
            E_IDLE: begin
                if (i_cmd.run) begin
                    n_code  = i_cmd.code;
                    n_last  = i_cmd.last;
                    n_clear = i_cmd.clear;
                    n_first = i_cmd.code[7:0];
                    n_count = '0;
                    pf_we    = i_cmd.last < NF_W'(TBL_SIZE - 1);
                    pf_waddr = MAX_CODE_BITS'(i_cmd.last + NF_W'(1));
                end else if (i_cmd.pop) begin
                    n_count = r_count - NF_W'(1);
                end
            end
            E_WALK: begin
                st_we    = 1'b1;
                st_wdata = sf_rdata;
                n_count  = r_count + NF_W'(1);
                n_first  = pf_rdata[7:0];
            end
            E_FIRST: begin
                st_we   = 1'b1;
                n_count = r_count + NF_W'(1);
                sf_we   = r_last < NF_W'(TBL_SIZE) && r_last >= r_clear + NF_W'(2);
                n_done  = NF_W'(r_code) != r_last;
            end
            E_FIX: begin
                // code equal to the entry being built: bottom of stack is its first byte
                st_we    = 1'b1;
                st_waddr = '0;
                n_done   = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
        r_code  <= n_code;
        r_last  <= n_last;
        r_clear <= n_clear;
        r_first <= n_first;
    end

    assign o_sts.done  = r_done;
    assign o_sts.empty = (r_count == '0);
    assign o_sts.pix   = st_rdata;

    a_run_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.run |-> r_state == E_IDLE)
        else $error("expander started while busy");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> r_count != '0)
        else $error("pop from empty stack");
    a_done_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_count != '0)
        else $error("expansion finished with empty stack");

endmodule

// File: hdl/gld_raster.sv
`timescale 1ns / 1ps
// Pixel column/row tracker with normal and four-pass interlaced row order.
module gld_raster
    import gld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [15:0] i_width,
    input  logic [15:0] i_height,
    input  logic        i_interlaced,
    output logic [15:0] o_col,
    output logic [15:0] o_row,
    output logic        o_row_end
);

    logic [15:0] r_col, n_col;
    logic [15:0] r_row, n_row;
    logic [1:0]  r_pass, n_pass;
    logic [16:0] wdt, hgt, y;
    logic [1:0]  p;

    assign wdt       = (i_width == '0) ? 17'd1 : {1'b0, i_width};
    assign hgt       = (i_height == '0) ? 17'd1 : {1'b0, i_height};
    assign o_row_end = ({1'b0, r_col} + 17'd1) >= wdt;

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_pass = r_pass;
        p      = r_pass;
        y      = {1'b0, r_row};
        if (i_step) begin
            if (o_row_end) begin
                n_col = '0;
                if (i_interlaced) begin
                    y = {1'b0, r_row} + ((r_pass < 2'd2) ? 17'd8 :
                                         ((r_pass == 2'd2) ? 17'd4 : 17'd2));
                    // skip passes that hold no rows
                    for (int i = 0; i < 3; i++) begin
                        if (y >= hgt && p < 2'd3) begin
                            p = p + 2'd1;
                            y = (p == 2'd1) ? 17'd4 : ((p == 2'd2) ? 17'd2 : 17'd1);
                        end
                    end
                    if (y >= hgt) begin
                        p = 2'd0;
                        y = '0;
                    end
                    n_pass = p;
                    n_row  = y[15:0];
                end else if ({1'b0, r_row} < hgt) begin
                    n_row = r_row + 16'd1;
                end
            end else begin
                n_col = r_col + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_pass <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_pass <= n_pass;
        end
    end

    assign o_col = r_col;
    assign o_row = r_row;

endmodule
